// ===== hw/rtl/bads_pkg.sv =====
package bads_pkg;

   localparam int SRC_MAX    = 256;
   localparam int DST_MAX    = 64;
   localparam int CELL_DEPTH = DST_MAX * DST_MAX;
   localparam int ADDR_W     = $clog2(CELL_DEPTH);
   localparam int POS_W      = $clog2(SRC_MAX);
   localparam int CELL_W     = $clog2(DST_MAX);
   localparam int NUM_W      = CELL_W + POS_W;
   localparam int STEP_W     = $clog2(NUM_W);
   localparam int SDIM_W     = 9;
   localparam int DDIM_W     = 7;
   localparam int TOTAL_W    = ADDR_W + 1;
   localparam int CHAN_W     = 16;
   localparam int SUM_W      = 33;
   localparam int CNT_W      = 17;
   localparam int DSTEP_W    = $clog2(SUM_W);
   localparam int CHAN_SHIFT = 14;
   localparam int CODE_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CODE_W-1:0] EMPTY_CODE = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   typedef enum logic {
      OP_ACCUM,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIVX,
      F_DIVY,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_EXEC,
      B_DIV,
      B_OUT
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic                last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [SUM_W-1:0] red_sum;
      logic [SUM_W-1:0] green_sum;
      logic [SUM_W-1:0] blue_sum;
      logic [CNT_W-1:0] count;
   } cell_word_type;

   typedef struct packed {
      logic [CNT_W-1:0] rem;
      logic [SUM_W-1:0] num;
   } div_lane_type;

endpackage

// ===== hw/rtl/bads_queue.sv =====
module bads_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bads_pkg::entry_type    push_entry,
   input  logic                   pop,
   output bads_pkg::entry_type    head,
   output bads_pkg::q_status_type status
);
   import bads_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop) else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/bads_front.sv =====
module bads_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [15:0]                     req_red,
   input  logic [15:0]                     req_green,
   input  logic [15:0]                     req_blue,
   input  logic                            req_transparent,
   input  logic                            csr_write,
   input  logic [bads_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bads_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            clearing,
   input  bads_pkg::q_status_type          q_status,
   output logic                            push,
   output bads_pkg::entry_type             push_entry
);
   import bads_pkg::*;

   front_state_type     state_ff, state_in;
   logic [SDIM_W-1:0]   src_w_ff, src_h_ff;
   logic [DDIM_W-1:0]   dst_w_ff, dst_h_ff;
   logic [POS_W-1:0]    col_ff, col_in, row_ff, row_in, y_ff, y_in;
   logic [ADDR_W-1:0]   ridx_ff, ridx_in;
   entry_type           ent_ff, ent_in;
   logic [CELL_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [NUM_W-1:0]    dnum_ff, dnum_in;
   logic [POS_W-1:0]    drem_ff, drem_in, ddiv_ff, ddiv_in;
   logic [STEP_W-1:0]   dstep_ff, dstep_in;

   logic [SDIM_W-1:0]   sw, sh;
   logic [DDIM_W-1:0]   dw0, dh0, dw, dh;
   logic [TOTAL_W-1:0]  total;
   logic [POS_W-1:0]    x, y;
   logic                accept, div_done;
   logic [POS_W:0]      trial;
   logic                ge;
   logic [NUM_W-1:0]    num_nx;
   logic [POS_W-1:0]    rem_nx;
   logic [CELL_W-1:0]   quot;
   logic [SDIM_W-1:0]   col_p1, row_p1;
   logic [ADDR_W-1:0]   ridx_eff;
   logic [TOTAL_W-1:0]  ridx_p1;

   always_comb begin
      sw = (src_w_ff == '0) ? SDIM_W'(1)
         : (src_w_ff > SDIM_W'(SRC_MAX)) ? SDIM_W'(SRC_MAX) : src_w_ff;
      sh = (src_h_ff == '0) ? SDIM_W'(1)
         : (src_h_ff > SDIM_W'(SRC_MAX)) ? SDIM_W'(SRC_MAX) : src_h_ff;
      dw0 = (dst_w_ff == '0) ? DDIM_W'(1)
          : (dst_w_ff > DDIM_W'(DST_MAX)) ? DDIM_W'(DST_MAX) : dst_w_ff;
      dh0 = (dst_h_ff == '0) ? DDIM_W'(1)
          : (dst_h_ff > DDIM_W'(DST_MAX)) ? DDIM_W'(DST_MAX) : dst_h_ff;
      dw = (SDIM_W'(dw0) > sw) ? sw[DDIM_W-1:0] : dw0;
      dh = (SDIM_W'(dh0) > sh) ? sh[DDIM_W-1:0] : dh0;
      total = TOTAL_W'(dw) * TOTAL_W'(dh);
      x = (SDIM_W'(col_ff) < sw) ? col_ff : POS_W'(sw - SDIM_W'(1));
      y = (SDIM_W'(row_ff) < sh) ? row_ff : POS_W'(sh - SDIM_W'(1));
   end

   // one quotient bit per cycle for the cell index
   always_comb begin
      trial    = {drem_ff, dnum_ff[NUM_W-1]};
      ge       = (trial >= {1'b0, ddiv_ff});
      rem_nx   = ge ? POS_W'(trial - {1'b0, ddiv_ff}) : trial[POS_W-1:0];
      num_nx   = {dnum_ff[NUM_W-2:0], ge};
      quot     = (ddiv_ff == '0) ? '0 : num_nx[CELL_W-1:0];
      div_done = (dstep_ff == STEP_W'(NUM_W - 1));
   end

   assign req_stall = (state_ff != F_IDLE) || clearing;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_action) begin
                  state_in = F_PUSH;
               end else if (!req_transparent) begin
                  state_in = F_DIVX;
               end
            end
         end
         F_DIVX: begin
            if (div_done) begin
               state_in = F_DIVY;
            end
         end
         F_DIVY: begin
            if (div_done) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      ridx_in  = ridx_ff;
      y_in     = y_ff;
      ent_in   = ent_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      dnum_in  = dnum_ff;
      drem_in  = drem_ff;
      ddiv_in  = ddiv_ff;
      dstep_in = dstep_ff;
      push     = 1'b0;
      push_entry = ent_ff;
      col_p1   = SDIM_W'(col_ff) + SDIM_W'(1);
      row_p1   = SDIM_W'(row_ff) + SDIM_W'(1);
      ridx_eff = ({1'b0, ridx_ff} >= total) ? '0 : ridx_ff;
      ridx_p1  = {1'b0, ridx_eff} + TOTAL_W'(1);
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               ent_in.red   = req_red;
               ent_in.green = req_green;
               ent_in.blue  = req_blue;
               if (req_action) begin
                  ent_in.op   = OP_READ;
                  ent_in.addr = ridx_eff;
                  ent_in.last = (ridx_p1 == total);
                  ridx_in     = (ridx_p1 >= total) ? '0 : ridx_p1[ADDR_W-1:0];
               end else begin
                  ent_in.op   = OP_ACCUM;
                  ent_in.last = 1'b0;
                  y_in        = y;
                  dnum_in     = NUM_W'(dw - DDIM_W'(1)) * NUM_W'(x);
                  ddiv_in     = POS_W'(sw - SDIM_W'(1));
                  drem_in     = '0;
                  dstep_in    = '0;
                  if (col_p1 >= sw) begin
                     col_in = '0;
                     row_in = (row_p1 >= sh) ? '0 : row_p1[POS_W-1:0];
                  end else begin
                     col_in = col_p1[POS_W-1:0];
                  end
               end
            end
         end
         F_DIVX: begin
            dnum_in  = num_nx;
            drem_in  = rem_nx;
            dstep_in = dstep_ff + STEP_W'(1);
            if (div_done) begin
               cx_in    = quot;
               dnum_in  = NUM_W'(dh - DDIM_W'(1)) * NUM_W'(y_ff);
               ddiv_in  = POS_W'(sh - SDIM_W'(1));
               drem_in  = '0;
               dstep_in = '0;
            end
         end
         F_DIVY: begin
            dnum_in  = num_nx;
            drem_in  = rem_nx;
            dstep_in = dstep_ff + STEP_W'(1);
            if (div_done) begin
               cy_in = quot;
            end
         end
         F_PUSH: begin
            push = !q_status.full;
            if (ent_ff.op == OP_ACCUM) begin
               push_entry.addr = ADDR_W'(TOTAL_W'(cy_ff) * TOTAL_W'(dw)
                                         + TOTAL_W'(cx_ff));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      ent_ff   <= ent_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      dnum_ff  <= dnum_in;
      drem_ff  <= drem_in;
      ddiv_ff  <= ddiv_in;
      dstep_ff <= dstep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         ridx_ff  <= '0;
         src_w_ff <= SDIM_W'(1);
         src_h_ff <= SDIM_W'(1);
         dst_w_ff <= DDIM_W'(1);
         dst_h_ff <= DDIM_W'(1);
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         ridx_ff  <= ridx_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w_ff <= csr_wdata;
               CSR_SRC_HEIGHT: src_h_ff <= csr_wdata;
               CSR_DST_WIDTH:  dst_w_ff <= csr_wdata[DDIM_W-1:0];
               CSR_DST_HEIGHT: dst_h_ff <= csr_wdata[DDIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

`ifndef ASSERT_OFF
   a_push_from_push_state: assert property (@(posedge clock) disable iff (reset)
      push |-> state_ff == F_PUSH)
      else $error("queue push outside push state");
`endif

endmodule

// ===== hw/rtl/bads_back.sv =====
module bads_back (
   input  logic                            clock,
   input  logic                            reset,
   input  bads_pkg::entry_type             head,
   input  bads_pkg::q_status_type          q_status,
   output logic                            pop,
   output logic                            clearing,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [6:0]                      rsp_color_code,
   output logic                            rsp_last_cell
);
   import bads_pkg::*;

   cell_word_type      mem [CELL_DEPTH];
   cell_word_type      rd_data_ff;
   back_state_type     state_ff, state_in;
   entry_type          cur_ff, cur_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [DSTEP_W-1:0] step_ff, step_in;
   div_lane_type       lane_r_ff, lane_r_in, lane_g_ff, lane_g_in, lane_b_ff, lane_b_in;
   logic [CNT_W-1:0]   div_ff, div_in;
   logic               empty_ff, empty_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  code_ff, code_in;
   logic               last_ff, last_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   cell_word_type      mem_wdata;
   logic               out_free, div_done;

   function automatic div_lane_type div_step(div_lane_type l, logic [CNT_W-1:0] d);
      logic [CNT_W:0] trial;
      logic           ge;
      div_lane_type   r;
      trial = {l.rem, l.num[SUM_W-1]};
      ge    = (trial >= {1'b0, d});
      r.rem = ge ? CNT_W'(trial - {1'b0, d}) : trial[CNT_W-1:0];
      r.num = {l.num[SUM_W-2:0], ge};
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign div_done = (step_ff == DSTEP_W'(SUM_W - 1));
   assign clearing = (state_ff == B_CLEAR);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(CELL_DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_status.empty) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            if (cur_ff.op == OP_ACCUM) begin
               state_in = B_IDLE;
            end else if (rd_data_ff.count == '0) begin
               state_in = B_OUT;
            end else begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (div_done) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff.addr;
      mem_wdata    = '0;
      cur_in       = cur_ff;
      clr_addr_in  = clr_addr_ff;
      step_in      = step_ff;
      lane_r_in    = lane_r_ff;
      lane_g_in    = lane_g_ff;
      lane_b_in    = lane_b_ff;
      div_in       = div_ff;
      empty_in     = empty_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         B_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         B_IDLE: begin
            pop    = !q_status.empty;
            cur_in = head;
         end
         B_EXEC: begin
            mem_we = 1'b1;
            if (cur_ff.op == OP_ACCUM) begin
               mem_wdata.red_sum   = rd_data_ff.red_sum + SUM_W'(cur_ff.red);
               mem_wdata.green_sum = rd_data_ff.green_sum + SUM_W'(cur_ff.green);
               mem_wdata.blue_sum  = rd_data_ff.blue_sum + SUM_W'(cur_ff.blue);
               mem_wdata.count     = rd_data_ff.count + CNT_W'(1);
            end
            lane_r_in = '{rem: '0, num: rd_data_ff.red_sum};
            lane_g_in = '{rem: '0, num: rd_data_ff.green_sum};
            lane_b_in = '{rem: '0, num: rd_data_ff.blue_sum};
            div_in    = rd_data_ff.count;
            empty_in  = (rd_data_ff.count == '0);
            step_in   = '0;
         end
         B_DIV: begin
            lane_r_in = div_step(lane_r_ff, div_ff);
            lane_g_in = div_step(lane_g_ff, div_ff);
            lane_b_in = div_step(lane_b_ff, div_ff);
            step_in   = step_ff + DSTEP_W'(1);
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               last_in      = cur_ff.last;
               code_in      = empty_ff ? EMPTY_CODE
                            : {1'b0, lane_r_ff.num[CHAN_SHIFT+1:CHAN_SHIFT],
                                     lane_g_ff.num[CHAN_SHIFT+1:CHAN_SHIFT],
                                     lane_b_ff.num[CHAN_SHIFT+1:CHAN_SHIFT]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[head.addr];
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      step_ff   <= step_in;
      lane_r_ff <= lane_r_in;
      lane_g_ff <= lane_g_in;
      lane_b_ff <= lane_b_in;
      div_ff    <= div_in;
      empty_ff  <= empty_in;
      code_ff   <= code_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_color_code = code_ff;
   assign rsp_last_cell  = last_ff;

`ifndef ASSERT_OFF
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == B_OUT)
      else $error("result raised outside output state");
   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop) else $error("queue popped during clearing pass");
`endif

endmodule

// ===== hw/rtl/box_average_downscale_rgb222.sv =====
// channel   direction  fields
// req       in         action, red, green, blue, transparent
// rsp       out        color_code, last_cell
// csr       in         index 0..3: src_width, src_height, dst_width, dst_height
//
// opaque pixel: two 14-step cell index divisions in the front
// readout: the 33-step average divider in the back, skipped for an empty cell
// transparent pixel: dropped in the front, no memory access
// after reset all 4096 cell memory words are cleared while req is stalled
// a stalled rsp holds its item; the front keeps taking items until the queue fills
module box_average_downscale_rgb222 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_red,
   input  logic [15:0] req_green,
   input  logic [15:0] req_blue,
   input  logic        req_transparent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_color_code,
   output logic        rsp_last_cell,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import bads_pkg::*;

   logic         push, pop, clearing;
   entry_type    push_entry, head;
   q_status_type q_status;

   bads_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_transparent (req_transparent),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .clearing        (clearing),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   bads_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   bads_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_color_code (rsp_color_code),
      .rsp_last_cell  (rsp_last_cell)
   );

endmodule
